/* src/tcp_pkg.sv */
// Package: geometry, character codes, status codes and field widths for the text cursor block.
`default_nettype none

package tcp_pkg;

  // Screen and font geometry in pixels
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int GLYPH_WIDTH   = 8;
  localparam int GLYPH_HEIGHT  = 16;
  localparam int FIRST_CODE    = 32;
  localparam int LAST_CODE     = 126;
  localparam int TAB_GLYPHS    = 4;
  localparam int TAB_STOP      = GLYPH_WIDTH * TAB_GLYPHS;

  // Stored cursor widths: column may reach SCREEN_WIDTH, row stays below SCREEN_HEIGHT
  localparam int COL_W = $clog2(SCREEN_WIDTH + 1);
  localparam int ROW_W = $clog2(SCREEN_HEIGHT);

  // Working width for position arithmetic (16-bit coordinates plus carry headroom)
  localparam int POS_W = 17;

  // Item field widths
  localparam int CHAR_W   = 8;
  localparam int COORD_W  = 16;
  localparam int COLOUR_W = 8;
  localparam int STATUS_W = 2;
  localparam int GIDX_W   = 7;
  localparam int GX_W     = 9;
  localparam int GY_W     = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  // Command modes
  localparam logic MODE_INIT = 1'b0;
  localparam logic MODE_PUT  = 1'b1;

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_QMARK = 8'd63;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NODEV = 2'd1,
    STATUS_INVAL = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* src/text_cursor_placement_top.sv */
// Top level: text console cursor controller with a streaming command input and result output.
//
// Usage: each input item is one console command. s_axis_tuser carries the mode
// (0 initialize, 1 place a character); s_axis_tdata carries the character code,
// the requested pixel position and the foreground colour. Every command gives
// exactly one result item on the master side with a status, clear/scroll/draw
// requests, the glyph placement and the cursor position stored afterwards.
//
// The result is registered: it appears in the cycle after its command is
// accepted. Throughput is one item per cycle while the receiver takes results;
// the single result register is the only stage, and the cursor registers update
// at the same edge so the next command already sees the new cursor.
//
// Reset clears the ready flag and puts the cursor at the origin; no result is
// pending. A placement before the first initialize reports "not initialized".
//
// When the receiver stalls, the result register holds its item and the input
// side stops accepting until the result is taken; once it is taken, a new
// command enters in the same cycle.
`default_nettype none

module text_cursor_placement_top
  import tcp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Command input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: char_code[7:0], pos_x[23:8], pos_y[39:24], colour[47:40]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode
  input  wire logic                  s_axis_tuser,
  // Result output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: status[1:0], clear_request[2], scroll_request[3], draw_request[4],
  //        glyph_index[11:5], glyph_x[20:12], glyph_y[28:21], glyph_colour[36:29],
  //        next_x[45:37], next_y[53:46], zero pad[55:54]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  // Unpacked input fields
  logic                 mode;
  logic [CHAR_W-1:0]    char_code;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic [COLOUR_W-1:0]  colour;

  assign mode      = s_axis_tuser;
  assign char_code = s_axis_tdata[7:0];
  assign pos_x     = s_axis_tdata[23:8];
  assign pos_y     = s_axis_tdata[39:24];
  assign colour    = s_axis_tdata[47:40];

  // State
  logic             ready_q, ready_d;
  logic [COL_W-1:0] cursor_col_q, cursor_col_d;
  logic [ROW_W-1:0] cursor_row_q, cursor_row_d;

  // Result register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic accept;

  // Take a new command whenever the result register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Result fields built for the command on the input
  status_e              res_status;
  logic                 res_clear;
  logic                 res_scroll;
  logic                 res_draw;
  logic [GIDX_W-1:0]    res_gidx;
  logic [GX_W-1:0]      res_gx;
  logic [GY_W-1:0]      res_gy;
  logic [COLOUR_W-1:0]  res_gcolour;
  logic [GX_W-1:0]      res_nx;
  logic [GY_W-1:0]      res_ny;

  always_comb begin
    logic             neg_x;
    logic             neg_y;
    logic             use_cursor;
    logic             invalid;
    logic             is_ctrl;
    logic             in_font;
    logic [CHAR_W-1:0] font_code;
    logic [CHAR_W-1:0] gidx_full;
    logic [POS_W-1:0] cur_x;
    logic [POS_W-1:0] cur_y;
    logic [POS_W-1:0] x0;
    logic [POS_W-1:0] y0;
    logic [POS_W-1:0] x1;
    logic [POS_W-1:0] y1;
    logic [POS_W-1:0] x2;
    logic [POS_W-1:0] y2;
    logic [POS_W-1:0] x3;
    logic [POS_W-1:0] tab_x;
    logic             scroll;

    cur_x = {{(POS_W-COL_W){1'b0}}, cursor_col_q};
    cur_y = {{(POS_W-ROW_W){1'b0}}, cursor_row_q};

    neg_x = pos_x[COORD_W-1];
    neg_y = pos_y[COORD_W-1];

    // Fall back to the stored cursor: both negative, row off screen, or the
    // cursor already on the last text row while a row of zero is asked for
    use_cursor = (neg_x && neg_y)
              || (!neg_y && ({1'b0, pos_y} >= POS_W'(SCREEN_HEIGHT)))
              || ((cur_y >= POS_W'(SCREEN_HEIGHT - GLYPH_HEIGHT)) && (pos_y == '0));
    invalid = !use_cursor && (neg_x != neg_y);

    x0 = use_cursor ? cur_x : {1'b0, pos_x};
    y0 = use_cursor ? cur_y : {1'b0, pos_y};

    // Advance to the next tab stop
    tab_x = POS_W'((x0 / POS_W'(TAB_STOP) + POS_W'(1)) * POS_W'(TAB_STOP));

    x1 = x0;
    y1 = y0;
    if (char_code == CODE_NL) begin
      x1 = '0;
      y1 = y0 + POS_W'(GLYPH_HEIGHT);
    end else if (char_code == CODE_CR) begin
      x1 = '0;
    end else if (char_code == CODE_TAB) begin
      if (tab_x >= POS_W'(SCREEN_WIDTH)) begin
        x1 = '0;
        y1 = y0 + POS_W'(GLYPH_HEIGHT);
      end else begin
        x1 = tab_x;
      end
    end else if (x0 + POS_W'(GLYPH_WIDTH) > POS_W'(SCREEN_WIDTH)) begin
      x1 = '0;
      y1 = y0 + POS_W'(GLYPH_HEIGHT);
    end

    // Past the bottom: request a scroll and pin to the last text row
    scroll = (y1 + POS_W'(GLYPH_HEIGHT)) > POS_W'(SCREEN_HEIGHT);
    x2 = scroll ? '0 : x1;
    y2 = scroll ? POS_W'(SCREEN_HEIGHT - GLYPH_HEIGHT) : y1;

    is_ctrl = (char_code == CODE_NL) || (char_code == CODE_CR) || (char_code == CODE_TAB);
    in_font = (char_code >= CHAR_W'(FIRST_CODE)) && (char_code <= CHAR_W'(LAST_CODE));
    font_code = in_font ? char_code : CODE_QMARK;
    gidx_full = font_code - CHAR_W'(FIRST_CODE);

    x3 = is_ctrl ? x2 : x2 + POS_W'(GLYPH_WIDTH);

    // Default: nothing requested, report the stored cursor, state holds
    res_status   = STATUS_OK;
    res_clear    = 1'b0;
    res_scroll   = 1'b0;
    res_draw     = 1'b0;
    res_gidx     = '0;
    res_gx       = '0;
    res_gy       = '0;
    res_gcolour  = '0;
    res_nx       = cur_x[GX_W-1:0];
    res_ny       = cur_y[GY_W-1:0];
    ready_d      = ready_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;

    if (mode == MODE_INIT) begin
      res_clear    = 1'b1;
      res_nx       = '0;
      res_ny       = '0;
      ready_d      = 1'b1;
      cursor_col_d = '0;
      cursor_row_d = '0;
    end else if (!ready_q) begin
      res_status = STATUS_NODEV;
    end else if (invalid) begin
      res_status = STATUS_INVAL;
    end else begin
      res_scroll = scroll;
      if (!is_ctrl) begin
        res_draw    = 1'b1;
        res_gidx    = gidx_full[GIDX_W-1:0];
        res_gx      = x2[GX_W-1:0];
        res_gy      = y2[GY_W-1:0];
        res_gcolour = colour;
      end
      res_nx       = x3[GX_W-1:0];
      res_ny       = y2[GY_W-1:0];
      cursor_col_d = x3[COL_W-1:0];
      cursor_row_d = y2[ROW_W-1:0];
    end
  end

  assign out_data_d = {2'b00, res_ny, res_nx, res_gcolour, res_gy, res_gx, res_gidx,
                       res_draw, res_scroll, res_clear, res_status};

  // Control state: cursor and ready flag advance only on an accepted command; valid loads while ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q      <= 1'b0;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        ready_q      <= ready_d;
        cursor_col_q <= cursor_col_d;
        cursor_row_q <= cursor_row_d;
      end
      if (s_axis_tready) begin
        out_valid_q <= s_axis_tvalid;
      end
    end
  end

  // Result payload: load on accept, hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

/* tb/text_cursor_checker.sv */
// Checker for the text cursor block: predicts each result item and compares it with the output.
module text_cursor_checker
  import tcp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  input  wire logic                  s_axis_tready_i,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,
  input  wire logic                  m_axis_tvalid_i,
  input  wire logic                  m_axis_tready_i,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e               status;
    logic                  clear_req;
    logic                  scroll_req;
    logic                  draw_req;
    logic [GIDX_W-1:0]     glyph_index;
    logic [GX_W-1:0]       glyph_x;
    logic [GY_W-1:0]       glyph_y;
    logic [COLOUR_W-1:0]   glyph_colour;
    logic [COL_W-1:0]      next_x;
    logic [ROW_W-1:0]      next_y;
  } console_result_t;

  // Console state as the block should hold it
  bit ready_flag = 1'b0;
  int cursor_col = 0;
  int cursor_row = 0;

  console_result_t expected_results[$];
  console_result_t want_result;
  console_result_t got_result;

  function automatic console_result_t apply_command(input logic mode,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic signed [COORD_W-1:0] px,
                                                    input logic signed [COORD_W-1:0] py,
                                                    input logic [COLOUR_W-1:0] colour);
    console_result_t r;
    int x;
    int y;
    int code;
    bit is_control;
    r = '0;
    if (mode == MODE_INIT) begin
      ready_flag = 1'b1;
      cursor_col = 0;
      cursor_row = 0;
      r.clear_req = 1'b1;
      return r;
    end
    if (!ready_flag) begin
      r.status = STATUS_NODEV;
      r.next_x = COL_W'(cursor_col);
      r.next_y = ROW_W'(cursor_row);
      return r;
    end
    x = px;
    y = py;
    // Fall back to the stored cursor; a lone negative coordinate is rejected
    if ((x < 0 && y < 0) || y >= SCREEN_HEIGHT ||
        (cursor_row >= SCREEN_HEIGHT - GLYPH_HEIGHT && y == 0)) begin
      x = cursor_col;
      y = cursor_row;
    end else if ((x < 0) != (y < 0)) begin
      r.status = STATUS_INVAL;
      r.next_x = COL_W'(cursor_col);
      r.next_y = ROW_W'(cursor_row);
      return r;
    end
    is_control = (ch == CODE_NL) || (ch == CODE_CR) || (ch == CODE_TAB);
    if (ch == CODE_NL) begin
      x = 0;
      y += GLYPH_HEIGHT;
    end else if (ch == CODE_CR) begin
      x = 0;
    end else if (ch == CODE_TAB) begin
      x = (x / TAB_STOP + 1) * TAB_STOP;
      if (x >= SCREEN_WIDTH) begin
        x = 0;
        y += GLYPH_HEIGHT;
      end
    end else if (x + GLYPH_WIDTH > SCREEN_WIDTH) begin
      x = 0;
      y += GLYPH_HEIGHT;
    end
    if (y + GLYPH_HEIGHT > SCREEN_HEIGHT) begin
      r.scroll_req = 1'b1;
      x = 0;
      y = SCREEN_HEIGHT - GLYPH_HEIGHT;
    end
    if (!is_control) begin
      code = ch;
      if (code < FIRST_CODE || code > LAST_CODE) code = CODE_QMARK;
      r.draw_req     = 1'b1;
      r.glyph_index  = GIDX_W'(code - FIRST_CODE);
      r.glyph_x      = GX_W'(x);
      r.glyph_y      = GY_W'(y);
      r.glyph_colour = colour;
      x += GLYPH_WIDTH;
    end
    cursor_col = x;
    cursor_row = y;
    r.next_x = COL_W'(x);
    r.next_y = ROW_W'(y);
    return r;
  endfunction

  function automatic console_result_t decode_result(input logic [OUT_DATA_W-1:0] d);
    console_result_t r;
    r.status       = status_e'(d[1:0]);
    r.clear_req    = d[2];
    r.scroll_req   = d[3];
    r.draw_req     = d[4];
    r.glyph_index  = d[11:5];
    r.glyph_x      = d[20:12];
    r.glyph_y      = d[28:21];
    r.glyph_colour = d[36:29];
    r.next_x       = d[45:37];
    r.next_y       = d[53:46];
    return r;
  endfunction

  function automatic string show_result(input console_result_t r);
    return $sformatf("st=%0d clr=%0b scr=%0b drw=%0b gi=%0d gx=%0d gy=%0d gc=%0d nx=%0d ny=%0d",
                     r.status, r.clear_req, r.scroll_req, r.draw_req, r.glyph_index,
                     r.glyph_x, r.glyph_y, r.glyph_colour, r.next_x, r.next_y);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_flag = 1'b0;
      cursor_col = 0;
      cursor_row = 0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(apply_command(s_axis_tuser_i, s_axis_tdata_i[7:0],
                                                 s_axis_tdata_i[23:8], s_axis_tdata_i[39:24],
                                                 s_axis_tdata_i[47:40]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got_result = decode_result(m_axis_tdata_i);
        if (expected_results.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("[%0t] ERROR: unexpected result item: got %s", $realtime,
                     show_result(got_result));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result !== want_result) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("[%0t] ERROR: result mismatch", $realtime);
              $display("  expected %s", show_result(want_result));
              $display("  actual   %s", show_result(got_result));
            end
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top: drives console commands into the text cursor block and gives the verdict.
module tb_top;
  import tcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;

  // Idle chances in percent for the command and result sides
  int cmd_gap_pct = 0;
  int result_stall_pct = 0;
  int stall_left = 0;

  text_cursor_placement_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  text_cursor_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .s_axis_tuser_i   (s_axis_tuser),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Guard against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: stall in bursts of random length, otherwise accept
  initial begin
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (result_stall_pct > 0 && $urandom_range(0, 99) < result_stall_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Present one command and hold it until the block takes it
  task automatic send_command(input logic mode, input logic [7:0] ch,
                              input logic [15:0] pos_x, input logic [15:0] pos_y,
                              input logic [7:0] colour);
    if (cmd_gap_pct > 0 && $urandom_range(0, 99) < cmd_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {colour, pos_y, pos_x, ch};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic put_char(input logic [7:0] ch, input logic [15:0] pos_x,
                          input logic [15:0] pos_y);
    send_command(MODE_PUT, ch, pos_x, pos_y, 8'($urandom_range(0, 255)));
  endtask

  // Random command: mostly well-formed placements, some noise and rejects
  task automatic send_random_command();
    logic        mode;
    logic [7:0]  ch;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    int          pick;
    mode = ($urandom_range(0, 49) == 0) ? MODE_INIT : MODE_PUT;
    pick = $urandom_range(0, 99);
    if (pick < 8)       ch = CODE_NL;
    else if (pick < 14) ch = CODE_CR;
    else if (pick < 20) ch = CODE_TAB;
    else if (pick < 85) ch = 8'($urandom_range(FIRST_CODE, LAST_CODE));
    else                ch = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // both negative: continue at the stored cursor
      pos_x = 16'($urandom_range(32768, 65535));
      pos_y = 16'($urandom_range(32768, 65535));
    end else if (pick < 70) begin
      pos_x = 16'($urandom_range(0, SCREEN_WIDTH + 10));
      pos_y = 16'($urandom_range(0, SCREEN_HEIGHT - 1));
    end else if (pick < 75) begin
      // top row request, redirected while the cursor sits on the last row
      pos_x = 16'($urandom_range(0, SCREEN_WIDTH - 1));
      pos_y = '0;
    end else if (pick < 82) begin
      pos_x = 16'($urandom_range(0, 65535));
      pos_y = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1)) begin
        pos_x[15] = 1'b1;
        pos_y[15] = 1'b0;
      end else begin
        pos_x[15] = 1'b0;
        pos_y[15] = 1'b1;
      end
    end else if (pick < 90) begin
      pos_x = 16'($urandom_range(0, 65535));
      pos_y = 16'($urandom_range(SCREEN_HEIGHT, 32767));
    end else begin
      pos_x = 16'($urandom_range(0, 65535));
      pos_y = 16'($urandom_range(0, 65535));
    end
    send_command(mode, ch, pos_x, pos_y, 8'($urandom_range(0, 255)));
  endtask

  task automatic run_random(input int count, input int gap_pct, input int stall_pct);
    cmd_gap_pct = gap_pct;
    result_stall_pct = stall_pct;
    repeat (count) send_random_command();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: placement before initialize is refused
    put_char("A", 16'd10, 16'd10);
    // Initialize with junk in the ignored fields
    send_command(MODE_INIT, 8'hFF, 16'hFFFF, 16'h8000, 8'hFF);
    // Stored cursor, both coordinates negative: most negative, then minus one
    send_command(MODE_PUT, "A", 16'h8000, 16'h8000, 8'h00);
    send_command(MODE_PUT, "B", 16'hFFFF, 16'hFFFF, 8'hFF);
    // One negative coordinate is invalid
    put_char("C", 16'hFFFF, 16'd5);
    put_char("D", 16'd5, 16'h8000);
    // Row off screen selects the cursor
    put_char("E", 16'd100, 16'(SCREEN_HEIGHT));
    put_char("F", 16'h7FFF, 16'h7FFF);
    // Largest in-screen row with a huge column: wrap, then scroll
    put_char("G", 16'h7FFF, 16'(SCREEN_HEIGHT - 1));
    // Right edge: last fitting column, then one past it
    put_char("H", 16'(SCREEN_WIDTH - GLYPH_WIDTH), 16'd40);
    put_char("I", 16'(SCREEN_WIDTH - GLYPH_WIDTH + 1), 16'd40);
    // Font range edges and substitution
    put_char(8'd0, 16'd0, 16'd60);
    put_char(8'd31, 16'hFFFF, 16'hFFFF);
    put_char(8'(FIRST_CODE), 16'hFFFF, 16'hFFFF);
    put_char(8'(LAST_CODE), 16'hFFFF, 16'hFFFF);
    put_char(8'd127, 16'hFFFF, 16'hFFFF);
    put_char(8'd255, 16'hFFFF, 16'hFFFF);
    // Tab stops, including the ones that wrap
    put_char(CODE_TAB, 16'd0, 16'd20);
    put_char(CODE_TAB, 16'd287, 16'd20);
    put_char(CODE_TAB, 16'd288, 16'd20);
    put_char(CODE_TAB, 16'd300, 16'd20);
    put_char(CODE_CR, 16'd150, 16'd80);
    // Last text row: a request for row 0 is redirected, newline then scrolls
    put_char("J", 16'd0, 16'(SCREEN_HEIGHT - GLYPH_HEIGHT));
    put_char("K", 16'd50, 16'd0);
    put_char(CODE_NL, 16'hFFFF, 16'hFFFF);

    // Random: both sides idling, then each side alone, then full rate
    run_random(350, 30, 30);
    run_random(300, 0, 40);
    run_random(150, 40, 0);
    run_random(200, 0, 0);
    s_axis_tvalid <= 1'b0;

    // Let the checker register the last item, then drain the results
    @(posedge clk_i);
    wait (pending_results == 0);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
